[hdl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion shorthands for the mapper checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while rst is high
`define CBI_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, disabled while rst is high
`define CBI_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

[hdl/cbirq_pkg.sv]
// ----------------------------------------------------------------------------
// cbirq_pkg
// Types and constants shared by the cartridge bank / cycle IRQ mapper.
// ----------------------------------------------------------------------------
`default_nettype none

package cbirq_pkg;

   // Item mode codes
   localparam logic MODE_WRITE = 1'b0;
   localparam logic MODE_TICK  = 1'b1;

   // Write decode mask and register addresses
   localparam logic [15:0] ADDR_MASK     = 16'hE003;
   localparam logic [15:0] ADDR_CHR_BANK = 16'h8000;
   localparam logic [15:0] ADDR_RAM_BANK = 16'hE000;
   localparam logic [15:0] ADDR_MIRROR   = 16'hE001;
   localparam logic [15:0] ADDR_IRQ_CTRL = 16'hE002;

   // Data bit positions
   localparam int MIRROR_BIT     = 3;
   localparam int IRQ_ENABLE_BIT = 1;

   localparam int COUNT_W = 15;

   typedef struct packed {
      logic        mode;
      logic [15:0] bus_address;
      logic [7:0]  bus_data;
   } req_type;

   typedef struct packed {
      logic [7:0] chr_bank;
      logic [3:0] ram_window_bank;
      logic       mirror_horizontal;
      logic       irq_line;
   } rsp_type;

   typedef struct packed {
      logic [COUNT_W-1:0] cycle_count;
      logic               irq_enabled;
      logic               irq_asserted;
      logic [7:0]         chr_bank;
      logic [3:0]         ram_bank;
      logic               mirror;
   } state_type;

endpackage

`default_nettype wire

[hdl/cbirq_core.sv]
// ----------------------------------------------------------------------------
// cbirq_core
// Mapper state: bank registers, mirroring, cycle counter and IRQ flag.
// Applies one item per exec pulse and presents the post-update outputs.
// ----------------------------------------------------------------------------
`default_nettype none

module cbirq_core
   import cbirq_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    exec,
   input  wire req_type item,
   output rsp_type      next_rsp
);

   state_type          state_ff;
   state_type          state_in;
   logic [COUNT_W-1:0] count_inc;

   assign count_inc = state_ff.cycle_count + COUNT_W'(1);

   // Decode the write or advance the counter
   always_comb begin
      state_in = state_ff;
      if (item.mode == MODE_TICK) begin
         if (state_ff.irq_enabled) begin
            state_in.cycle_count = count_inc;
            // IRQ follows a change of the top two count bits
            if (count_inc[COUNT_W-1:COUNT_W-2] != state_ff.cycle_count[COUNT_W-1:COUNT_W-2]) begin
               state_in.irq_asserted = &count_inc[COUNT_W-1:COUNT_W-2];
            end
         end
      end else begin
         unique case (item.bus_address & ADDR_MASK)
            ADDR_CHR_BANK: begin
               state_in.chr_bank = item.bus_data;
            end
            ADDR_RAM_BANK: begin
               state_in.ram_bank = item.bus_data[3:0];
            end
            ADDR_MIRROR: begin
               state_in.mirror = item.bus_data[MIRROR_BIT];
            end
            ADDR_IRQ_CTRL: begin
               state_in.irq_enabled = item.bus_data[IRQ_ENABLE_BIT];
               if (!item.bus_data[IRQ_ENABLE_BIT]) begin
                  state_in.cycle_count  = '0;
                  state_in.irq_asserted = 1'b0;
               end
            end
            default: begin
               // unmapped write: drop
            end
         endcase
      end
   end

   // Commit the update on exec
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (exec) begin
         state_ff <= state_in;
      end
   end

   // Outputs after the update
   assign next_rsp.chr_bank          = state_in.chr_bank;
   assign next_rsp.ram_window_bank   = state_in.ram_bank;
   assign next_rsp.mirror_horizontal = state_in.mirror;
   assign next_rsp.irq_line          = state_in.irq_asserted;

endmodule

`default_nettype wire

[hdl/cartridge_bank_and_cycle_irq_top.sv]
// A transfer captured in the input register passes through the state update
// into the result register; while the result side is stalled and the result
// register is full, the transfer waits in the input register.
// Throughput: one item per cycle unless the result side stalls; the state update
// is a single pass between the input register and the result register.
// Reset: synchronous, active high; clears both valid flags and all mapper state.
// ----------------------------------------------------------------------------
// cartridge_bank_and_cycle_irq_top
// Mapper top level: input register, state update, result register.
// ----------------------------------------------------------------------------
`default_nettype none

module cartridge_bank_and_cycle_irq_top
   import cbirq_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_item,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_item
);

   logic    in_valid_ff;
   logic    in_valid_in;
   req_type in_item_ff;
   logic    rsp_valid_ff;
   logic    rsp_valid_in;
   rsp_type rsp_item_ff;
   rsp_type next_rsp;
   logic    advance;
   logic    exec;

   // Move the input stage forward whenever the result register is free
   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign exec      = in_valid_ff && advance;
   assign req_stall = in_valid_ff && !advance;

   assign in_valid_in  = req_stall ? in_valid_ff : req_valid;
   assign rsp_valid_in = advance ? in_valid_ff : rsp_valid_ff;

   // Valid flags
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Capture the input transfer
   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_item_ff <= req_item;
      end
   end

   // Capture the updated outputs
   always_ff @(posedge clock) begin
      if (exec) begin
         rsp_item_ff <= next_rsp;
      end
   end

   cbirq_core u_core (
      .clock    (clock),
      .reset    (reset),
      .exec     (exec),
      .item     (in_item_ff),
      .next_rsp (next_rsp)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

endmodule

`default_nettype wire

[hdl/cbirq_checker.sv]
// ----------------------------------------------------------------------------
// cbirq_checker
// Port-level checks on the mapper top level, bound to every instance.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module cbirq_checker
   import cbirq_pkg::*;
(
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    req_valid,
   input wire logic    req_stall,
   input wire logic    rsp_valid,
   input wire logic    rsp_stall,
   input wire rsp_type rsp_item
);

   logic req_xfer;

   assign req_xfer = req_valid && !req_stall;

   // A stalled result holds its payload
   `CBI_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_item))

   // Reset empties the result register
   `CBI_ASSERT_NEXT(a_rsp_reset, clock, 1'b0, reset, !rsp_valid)

   // An empty result register never back-pressures the input
   `CBI_ASSERT_NOW(a_no_stall_when_empty, clock, reset, !rsp_valid, !req_stall)

   // A held input item stalls exactly when the result is stalled
   `CBI_ASSERT_NEXT(a_held_stall, clock, reset, req_xfer, req_stall == (rsp_valid && rsp_stall))

endmodule

bind cartridge_bank_and_cycle_irq_top cbirq_checker u_cbirq_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_item  (rsp_item)
);

`default_nettype wire

[dv/mapper_state_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mapper_state_checker
// Watches both channels of the mapper, keeps its own copy of the bank, mirror
// and cycle IRQ state, and compares every result transfer, field by field,
// with the oldest outstanding prediction.
// ----------------------------------------------------------------------------

module mapper_state_checker
   import cbirq_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_stall,
   input  req_type req_item,
   input  logic    rsp_valid,
   input  logic    rsp_stall,
   input  rsp_type rsp_item,
   output int      mismatch_count,
   output int      outputs_due
);

   // Predicted mapper state
   logic [COUNT_W-1:0] cycle_count;
   logic               irq_enabled;
   logic               irq_raised;
   logic [7:0]         chr_bank;
   logic [3:0]         ram_bank;
   logic               mirror;

   rsp_type mapper_outputs_due[$];

   // Apply one bus write or CPU tick and return the outputs after the update
   function automatic rsp_type apply_item(input req_type item);
      logic [COUNT_W-1:0] next_count;
      rsp_type            outputs;
      if (item.mode == MODE_TICK) begin
         if (irq_enabled) begin
            next_count = cycle_count + 1'b1;
            // raise on entry to the top quarter, drop on any other change
            if (next_count[COUNT_W-1 -: 2] != cycle_count[COUNT_W-1 -: 2])
               irq_raised = (next_count[COUNT_W-1 -: 2] == 2'b11);
            cycle_count = next_count;
         end
      end else begin
         case (item.bus_address & ADDR_MASK)
            ADDR_CHR_BANK: chr_bank = item.bus_data;
            ADDR_RAM_BANK: ram_bank = item.bus_data[3:0];
            ADDR_MIRROR:   mirror   = item.bus_data[MIRROR_BIT];
            ADDR_IRQ_CTRL: begin
               irq_enabled = item.bus_data[IRQ_ENABLE_BIT];
               if (!irq_enabled) begin
                  cycle_count = '0;
                  irq_raised  = 1'b0;
               end
            end
            default: ;
         endcase
      end
      outputs.chr_bank          = chr_bank;
      outputs.ram_window_bank   = ram_bank;
      outputs.mirror_horizontal = mirror;
      outputs.irq_line          = irq_raised;
      return outputs;
   endfunction

   function automatic int field_differs(input string field, input int want, input int got);
      if (want == got)
         return 0;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
      return 1;
   endfunction

   // Compare result transfers, then predict for request transfers
   always @(posedge clock) begin
      rsp_type want;
      int      bad;
      if (reset) begin
         cycle_count = '0;
         irq_enabled = 1'b0;
         irq_raised  = 1'b0;
         chr_bank    = '0;
         ram_bank    = '0;
         mirror      = 1'b0;
         mapper_outputs_due.delete();
         mismatch_count <= 0;
         outputs_due    <= 0;
      end else begin
         bad = 0;
         if (rsp_valid && !rsp_stall) begin
            if (mapper_outputs_due.size() == 0) begin
               $display("%0t: unexpected result, expected none, actual %p", $time, rsp_item);
               bad++;
            end else begin
               want = mapper_outputs_due.pop_front();
               bad += field_differs("chr_bank", want.chr_bank, rsp_item.chr_bank);
               bad += field_differs("ram_window_bank", want.ram_window_bank,
                                    rsp_item.ram_window_bank);
               bad += field_differs("mirror_horizontal", want.mirror_horizontal,
                                    rsp_item.mirror_horizontal);
               bad += field_differs("irq_line", want.irq_line, rsp_item.irq_line);
            end
         end
         if (req_valid && !req_stall)
            mapper_outputs_due.push_back(apply_item(req_item));
         mismatch_count <= mismatch_count + bad;
         outputs_due    <= mapper_outputs_due.size();
      end
   end

endmodule

[dv/tb_cartridge_bank_and_cycle_irq_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_cartridge_bank_and_cycle_irq_top
// Drives bus writes and CPU ticks into the mapper: a directed pass over the
// decode aliases and enable corners, then random traffic with a stretch of
// no idling. Both sides idle at random; the checker decides.
// ----------------------------------------------------------------------------

module tb_cartridge_bank_and_cycle_irq_top;
   import cbirq_pkg::*;

   localparam int CYCLE_LIMIT   = 20000;
   localparam int RANDOM_ITEMS  = 632;
   localparam int NO_IDLE_START = 200;
   localparam int NO_IDLE_STOP  = 360;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   req_type req_item  = '0;
   logic    rsp_stall = 1'b0;
   logic    req_stall;
   logic    rsp_valid;
   rsp_type rsp_item;

   int mismatch_count;
   int outputs_due;
   int cycles  = 0;
   int gap_pct = 25;

   cartridge_bank_and_cycle_irq_top i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

   mapper_state_checker i_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_item       (req_item),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_item       (rsp_item),
      .mismatch_count (mismatch_count),
      .outputs_due    (outputs_due)
   );

   always #4 clock = ~clock;

   // Stall the result side at random and bound the run
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < gap_pct);
      cycles    <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   function automatic req_type bus_write(input logic [15:0] addr, input logic [7:0] data);
      req_type item;
      item.mode        = MODE_WRITE;
      item.bus_address = addr;
      item.bus_data    = data;
      return item;
   endfunction

   // Tick operands carry noise; the mapper ignores them
   function automatic req_type cpu_tick();
      req_type item;
      item.mode        = MODE_TICK;
      item.bus_address = 16'($urandom);
      item.bus_data    = 8'($urandom);
      return item;
   endfunction

   // Idle at random, then hold the item until the transfer happens
   task automatic transfer_item(input req_type item);
      while ($urandom_range(0, 99) < gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_item  <= item;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
   endtask

   // Stop sending until every predicted result has come back
   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outputs_due != 0)
         @(posedge clock);
   endtask

   initial begin
      logic [15:0] addr;
      logic [7:0]  data;
      int          pick;

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed: decode aliases, masking, unmapped writes, enable corners
      transfer_item(cpu_tick());
      transfer_item(bus_write(16'h8000, 8'hFF));
      transfer_item(bus_write(16'h9FFC, 8'h5A));
      transfer_item(bus_write(ADDR_RAM_BANK, 8'hFF));
      transfer_item(bus_write(16'hFFFC, 8'h00));
      transfer_item(bus_write(ADDR_MIRROR, 8'h08));
      transfer_item(bus_write(16'hFFFD, 8'hF7));
      transfer_item(bus_write(ADDR_MIRROR, 8'hFF));
      transfer_item(bus_write(16'h0000, 8'hFF));
      transfer_item(bus_write(16'hFFFF, 8'h00));
      transfer_item(bus_write(16'h8001, 8'hFF));
      transfer_item(bus_write(16'h6000, 8'h55));
      transfer_item(bus_write(ADDR_IRQ_CTRL, 8'h02));
      transfer_item(cpu_tick());
      transfer_item(bus_write(16'hFFFE, 8'hFF));
      transfer_item(cpu_tick());
      transfer_item(bus_write(ADDR_IRQ_CTRL, 8'hFD));
      transfer_item(cpu_tick());
      drain_results();

      // Random traffic: mostly decoded writes and ticks, some raw addresses
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         // long stretch with no idling on either side
         if (n == NO_IDLE_START)
            gap_pct = 0;
         if (n == NO_IDLE_STOP)
            gap_pct = 25;
         pick = $urandom_range(0, 99);
         data = 8'($urandom);
         if (pick < 40) begin
            transfer_item(cpu_tick());
         end else if (pick < 80) begin
            case ($urandom_range(0, 3))
               0: addr = ADDR_CHR_BANK;
               1: addr = ADDR_RAM_BANK;
               2: addr = ADDR_MIRROR;
               default: begin
                  addr = ADDR_IRQ_CTRL;
                  // lean toward enabled so ticks keep counting
                  if ($urandom_range(0, 3) != 0)
                     data[IRQ_ENABLE_BIT] = 1'b1;
               end
            endcase
            addr = addr | (16'($urandom) & ~ADDR_MASK);
            transfer_item(bus_write(addr, data));
         end else begin
            transfer_item(bus_write(16'($urandom), data));
         end
         if (n == RANDOM_ITEMS / 4)
            drain_results();
      end

      drain_results();
      repeat (4) @(posedge clock);
      if (mismatch_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

[files.f]
+incdir+hdl
hdl/cbirq_pkg.sv
hdl/cbirq_core.sv
hdl/cartridge_bank_and_cycle_irq_top.sv
hdl/cbirq_checker.sv
dv/mapper_state_checker.sv
dv/tb_cartridge_bank_and_cycle_irq_top.sv
